// ===== src/sn2d_pkg.sv =====
// Shared constants, types and gradient tables for the 2D simplex noise block.
package sn2d_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;

  // Offset and index widths (offsets in signed Q.30)
  localparam int OFS_W  = 34;
  localparam int IDX_W  = 34;
  localparam int HASH_W = 9;
  localparam int FOLD_W = 22;

  localparam logic signed [OFS_W-1:0] Q_ONE   = 34'sd1073741824;
  localparam logic signed [OFS_W-1:0] Q_HALF  = 34'sd536870912;
  localparam logic signed [OFS_W-1:0] UNSK_S  = 34'sd226908346;
  localparam logic signed [OFS_W-1:0] UNSK2_S = -34'sd619925132;

  localparam logic [28:0] SKEW_Q  = 29'd393016785;
  localparam logic [27:0] UNSK_Q  = 28'd226908346;
  localparam logic [30:0] TAY_A_Q = 31'd1925050421;
  localparam logic [29:0] TAY_B_Q = 30'd916690677;

  // mod 289 by reciprocal: floor(2^32 / 289)
  localparam logic [23:0]       RECIP289 = 24'd14861478;
  localparam logic [HASH_W-1:0] MOD_P    = 9'd289;

  // mod 41 by reciprocal: floor(2^12 / 41)
  localparam logic [6:0] RECIP41 = 7'd99;
  localparam logic [5:0] GRAD_N  = 6'd41;

  // Index fold: 2^18 mod 289 = 21, bias is a multiple of 289 above 2^33
  localparam logic [4:0]  FOLD_MUL = 5'd21;
  localparam logic [34:0] IDX_BIAS = 35'd9697230848;

  typedef logic signed [31:0] grad_tab_t [0:40];

  // One corner request into the corner pipeline
  typedef struct packed {
    logic signed [OFS_W-1:0] ox;
    logic signed [OFS_W-1:0] oy;
    logic [HASH_W-1:0]       hash;
  } corner_in_t;

  // Diamond x component, rounded to nearest, halves away from zero
  function automatic grad_tab_t make_a0();
    grad_tab_t tab;
    longint d;
    longint n;
    longint q;
    for (int i = 0; i < 41; i++) begin
      d = 2 * i - 41;
      if (d <= -21) n = d + 41;
      else if (d >= 21) n = d - 41;
      else n = d;
      q = ((n < 0 ? -n : n) * 64'sd1073741824 + 64'sd20) / 41;
      tab[i] = 32'(n < 0 ? -q : q);
    end
    return tab;
  endfunction

  // Diamond y component, rounded to nearest, halves away from zero
  function automatic grad_tab_t make_h();
    grad_tab_t tab;
    longint d;
    longint n;
    longint q;
    for (int i = 0; i < 41; i++) begin
      d = 2 * i - 41;
      n = 2 * (d < 0 ? -d : d) - 41;
      q = ((n < 0 ? -n : n) * 64'sd1073741824 + 64'sd41) / 82;
      tab[i] = 32'(n < 0 ? -q : q);
    end
    return tab;
  endfunction

  localparam grad_tab_t GRAD_A0 = make_a0();
  localparam grad_tab_t GRAD_H  = make_h();

endpackage

// ===== src/sn2d_in_if.sv =====
// Coordinate request channel.
interface sn2d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, x_coord, y_coord, input ready);
  modport sink (input valid, x_coord, y_coord, output ready);
endinterface

// ===== src/sn2d_out_if.sv =====
// Noise result channel.
interface sn2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

// ===== src/sn2d_mod289.sv =====
// Two-stage reduction of a 22-bit value mod 289 by reciprocal multiply.
module sn2d_mod289 import sn2d_pkg::*; (
  input  logic              clk,
  input  logic              ce,
  input  logic [FOLD_W-1:0] val,
  output logic [HASH_W-1:0] res
);

  logic [FOLD_W-1:0] val_r;
  logic [13:0]       quo_r;
  logic [45:0]       prod;
  logic [9:0]        rem_w;
  logic [HASH_W-1:0] res_nxt;
  logic [HASH_W-1:0] res_r;

  // Estimate the quotient, low by at most one
  assign prod = 46'(val) * 46'(RECIP289);

  always_ff @(posedge clk) begin
    if (ce) begin
      val_r <= val;
      quo_r <= prod[45:32];
    end
  end

  // Take the remainder and correct once
  assign rem_w   = 10'(val_r - FOLD_W'(quo_r) * FOLD_W'(MOD_P));
  assign res_nxt = (rem_w >= 10'(MOD_P)) ? HASH_W'(rem_w - 10'(MOD_P)) : rem_w[8:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== src/sn2d_corner.sv =====
// Seven-stage pipeline for one simplex corner contribution in Q.30.
module sn2d_corner import sn2d_pkg::*; (
  input  logic               clk,
  input  logic               ce,
  input  corner_in_t         cin,
  output logic signed [31:0] contrib
);

  // Stage 1: squared offsets, mod 41 quotient
  logic [OFS_W-1:0]        magx, magy;
  logic [67:0]             sqx_full, sqy_full;
  logic [15:0]             q41_full;
  logic [34:0]             sqx_r, sqy_r;
  logic [3:0]              quo41_r;
  logic [HASH_W-1:0]       hash_r;
  logic signed [OFS_W-1:0] ox1_r, oy1_r;

  assign magx     = cin.ox[OFS_W-1] ? OFS_W'(-cin.ox) : OFS_W'(cin.ox);
  assign magy     = cin.oy[OFS_W-1] ? OFS_W'(-cin.oy) : OFS_W'(cin.oy);
  assign sqx_full = 68'(magx) * 68'(magx);
  assign sqy_full = 68'(magy) * 68'(magy);
  assign q41_full = 16'(cin.hash) * 16'(RECIP41);

  always_ff @(posedge clk) begin
    if (ce) begin
      sqx_r   <= sqx_full[64:30];
      sqy_r   <= sqy_full[64:30];
      quo41_r <= q41_full[15:12];
      hash_r  <= cin.hash;
      ox1_r   <= cin.ox;
      oy1_r   <= cin.oy;
    end
  end

  // Stage 2: falloff base, gradient lookup
  logic [35:0]             r2;
  logic [29:0]             t_nxt;
  logic [HASH_W-1:0]       pm9;
  logic [5:0]              pm;
  logic [29:0]             t_r;
  logic signed [31:0]      a0_r, h_r;
  logic signed [OFS_W-1:0] ox2_r, oy2_r;

  assign r2    = 36'(sqx_r) + 36'(sqy_r);
  // clamp far corners to zero weight
  assign t_nxt = (r2 >= 36'(Q_HALF)) ? '0 : 30'(36'(Q_HALF) - r2);
  assign pm9   = hash_r - HASH_W'(HASH_W'(quo41_r) * HASH_W'(GRAD_N));
  assign pm    = (pm9 >= HASH_W'(GRAD_N)) ? 6'(pm9 - HASH_W'(GRAD_N)) : pm9[5:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      t_r   <= t_nxt;
      a0_r  <= GRAD_A0[pm];
      h_r   <= GRAD_H[pm];
      ox2_r <= ox1_r;
      oy2_r <= oy1_r;
    end
  end

  // Stage 3: t^2, gradient norm parts, dot product parts
  logic [59:0]        tsq;
  logic signed [63:0] asq, hsq;
  logic signed [65:0] dpx, dpy;
  logic [29:0]        tt_r;
  logic [31:0]        sa_r, sh_r;
  logic signed [65:0] dpx_r, dpy_r;

  assign tsq = 60'(t_r) * 60'(t_r);
  assign asq = 64'(a0_r) * 64'(a0_r);
  assign hsq = 64'(h_r) * 64'(h_r);
  assign dpx = 66'(a0_r) * 66'(ox2_r);
  assign dpy = 66'(h_r) * 66'(oy2_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      tt_r  <= tsq[59:30];
      sa_r  <= asq[61:30];
      sh_r  <= hsq[61:30];
      dpx_r <= dpx;
      dpy_r <= dpy;
    end
  end

  // Stage 4: t^4, norm, dot product
  logic [59:0]        msq;
  logic signed [65:0] dsum;
  logic [29:0]        m4_r;
  logic [31:0]        nrm_r;
  logic signed [OFS_W-1:0] g4_r;

  assign msq  = 60'(tt_r) * 60'(tt_r);
  assign dsum = dpx_r + dpy_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      m4_r  <= msq[59:30];
      nrm_r <= sa_r + sh_r;
      g4_r  <= OFS_W'(dsum >>> 30);
    end
  end

  // Stage 5: Taylor inverse-sqrt correction
  logic [61:0]             nprod;
  logic [31:0]             corr_r;
  logic [29:0]             m5_r;
  logic signed [OFS_W-1:0] g5_r;

  assign nprod = 62'(TAY_B_Q) * 62'(nrm_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      corr_r <= 32'(TAY_A_Q) - nprod[61:30];
      m5_r   <= m4_r;
      g5_r   <= g4_r;
    end
  end

  // Stage 6: weight times correction
  logic [61:0]             mqprod;
  logic [31:0]             mq_r;
  logic signed [OFS_W-1:0] g6_r;

  assign mqprod = 62'(m5_r) * 62'(corr_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      mq_r <= mqprod[61:30];
      g6_r <= g5_r;
    end
  end

  // Stage 7: contribution
  logic signed [66:0] cprod;
  logic signed [66:0] cshift;
  logic signed [31:0] contrib_r;

  assign cprod  = 67'($signed({1'b0, mq_r})) * 67'(g6_r);
  assign cshift = cprod >>> 30;

  always_ff @(posedge clk) begin
    if (ce) begin
      contrib_r <= cshift[31:0];
    end
  end

  assign contrib = contrib_r;

endmodule

// ===== src/simplex_noise_2d_top.sv =====
// Depth: 21 register stages; out valid rises once a taken request has passed through all of them.
// Throughput: one request per cycle; the result register and all stages
// freeze together while the result is not taken.
// Skew multiply, mod 289 hashing and the corner multiplier chain set the depth.
// Reset (rst_n, synchronous) clears the stage valid bits only.
module simplex_noise_2d_top import sn2d_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sn2d_in_if.sink    in_ch,
  sn2d_out_if.source out_ch
);

  localparam int NST = 21;

  typedef struct packed {
    logic signed [OFS_W-1:0] ox0;
    logic signed [OFS_W-1:0] oy0;
    logic signed [OFS_W-1:0] ox1;
    logic signed [OFS_W-1:0] oy1;
    logic signed [OFS_W-1:0] ox2;
    logic signed [OFS_W-1:0] oy2;
  } ofs_set_t;

  function automatic logic [FOLD_W-1:0] perm_poly(logic [HASH_W-1:0] a);
    logic [FOLD_W-1:0] k;
    k = FOLD_W'(a) * FOLD_W'(34) + FOLD_W'(1);
    return k * FOLD_W'(a);
  endfunction

  function automatic logic [HASH_W-1:0] red289(logic [9:0] v);
    return (v >= 10'(MOD_P)) ? HASH_W'(v - 10'(MOD_P)) : v[8:0];
  endfunction

  logic           ce;
  logic [NST:1]   vld_r;

  // Advance everything unless the result is held
  assign ce           = !vld_r[NST] || out_ch.ready;
  assign in_ch.ready  = ce;
  assign out_ch.valid = vld_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NST-1:1], in_ch.valid};
    end
  end

  // Stage 1: skew factor
  logic signed [32:0] xy_sum;
  logic signed [62:0] skew_prod;
  logic signed [31:0] x1_r, y1_r;
  logic signed [62:0] s1_r;

  assign xy_sum    = 33'(in_ch.x_coord) + 33'(in_ch.y_coord);
  assign skew_prod = 63'(xy_sum) * 63'($signed({1'b0, SKEW_Q}));

  always_ff @(posedge clk) begin
    if (ce) begin
      x1_r <= in_ch.x_coord;
      y1_r <= in_ch.y_coord;
      s1_r <= skew_prod;
    end
  end

  // Stage 2: cell index
  logic signed [63:0]      accx, accy;
  logic signed [31:0]      x2_r, y2_r;
  logic signed [IDX_W-1:0] ix2_r, iy2_r;

  assign accx = 64'($signed({x1_r, 30'b0})) + 64'(s1_r);
  assign accy = 64'($signed({y1_r, 30'b0})) + 64'(s1_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      x2_r  <= x1_r;
      y2_r  <= y1_r;
      ix2_r <= IDX_W'(accx >>> (COORD_FRAC_BITS + 30));
      iy2_r <= IDX_W'(accy >>> (COORD_FRAC_BITS + 30));
    end
  end

  // Stage 3: fractional parts, unskew term, index fold for hashing
  logic signed [63:0]      dx_full, dy_full, tprod;
  logic signed [34:0]      isum;
  logic [34:0]             ubx, uby;
  logic [FOLD_W-1:0]       fx, fy;
  logic signed [OFS_W-1:0] dx3_r, dy3_r, t3_r;
  logic [FOLD_W-1:0]       fx3_r, fy3_r;

  assign dx_full = (64'(x2_r) - (64'(ix2_r) <<< COORD_FRAC_BITS)) <<< (30 - COORD_FRAC_BITS);
  assign dy_full = (64'(y2_r) - (64'(iy2_r) <<< COORD_FRAC_BITS)) <<< (30 - COORD_FRAC_BITS);
  assign isum    = 35'(ix2_r) + 35'(iy2_r);
  assign tprod   = 64'(isum) * 64'($signed({1'b0, UNSK_Q}));
  assign ubx     = 35'(ix2_r) + IDX_BIAS;
  assign uby     = 35'(iy2_r) + IDX_BIAS;
  assign fx      = FOLD_W'(ubx[34:18]) * FOLD_W'(FOLD_MUL) + FOLD_W'(ubx[17:0]);
  assign fy      = FOLD_W'(uby[34:18]) * FOLD_W'(FOLD_MUL) + FOLD_W'(uby[17:0]);

  always_ff @(posedge clk) begin
    if (ce) begin
      dx3_r <= OFS_W'(dx_full);
      dy3_r <= OFS_W'(dy_full);
      t3_r  <= OFS_W'(tprod);
      fx3_r <= fx;
      fy3_r <= fy;
    end
  end

  // Stages 4-5: cell index mod 289
  logic [HASH_W-1:0] mx5, my5;

  sn2d_mod289 u_modx (.clk(clk), .ce(ce), .val(fx3_r), .res(mx5));
  sn2d_mod289 u_mody (.clk(clk), .ce(ce), .val(fy3_r), .res(my5));

  // Stage 4: first corner offset
  logic signed [OFS_W-1:0] x0x4_r, x0y4_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      x0x4_r <= dx3_r + t3_r;
      x0y4_r <= dy3_r + t3_r;
    end
  end

  // Stage 5: middle corner choice and all corner offsets
  logic     sx5;
  ofs_set_t ofs5;
  ofs_set_t ofs_d_r [5:12];
  logic     sx_d_r  [5:8];

  assign sx5      = x0x4_r > x0y4_r;
  assign ofs5.ox0 = x0x4_r;
  assign ofs5.oy0 = x0y4_r;
  assign ofs5.ox1 = x0x4_r + UNSK_S - (sx5 ? Q_ONE : '0);
  assign ofs5.oy1 = x0y4_r + UNSK_S - (sx5 ? '0 : Q_ONE);
  assign ofs5.ox2 = x0x4_r + UNSK2_S;
  assign ofs5.oy2 = x0y4_r + UNSK2_S;

  // Carry offsets and the corner choice alongside the hash pipeline
  always_ff @(posedge clk) begin
    if (ce) begin
      ofs_d_r[5] <= ofs5;
      sx_d_r[5]  <= sx5;
      for (int k = 6; k <= 12; k++) ofs_d_r[k] <= ofs_d_r[k-1];
      for (int k = 6; k <= 8; k++) sx_d_r[k] <= sx_d_r[k-1];
    end
  end

  // Stages 6-8: first permutation of the row index
  logic [HASH_W-1:0] my_inc;
  logic [FOLD_W-1:0] wa6_r, wb6_r;
  logic [HASH_W-1:0] mx_d_r [6:8];
  logic [HASH_W-1:0] pa8, pb8;

  assign my_inc = (my5 == MOD_P - 9'd1) ? '0 : my5 + 9'd1;

  always_ff @(posedge clk) begin
    if (ce) begin
      wa6_r     <= perm_poly(my5);
      wb6_r     <= perm_poly(my_inc);
      mx_d_r[6] <= mx5;
      mx_d_r[7] <= mx_d_r[6];
      mx_d_r[8] <= mx_d_r[7];
    end
  end

  sn2d_mod289 u_perm_a (.clk(clk), .ce(ce), .val(wa6_r), .res(pa8));
  sn2d_mod289 u_perm_b (.clk(clk), .ce(ce), .val(wb6_r), .res(pb8));

  // Stage 9: second permutation arguments, reduced below 289
  logic [9:0]        arg0, arg1, arg2;
  logic [HASH_W-1:0] args9_r [3];

  assign arg0 = 10'(pa8) + 10'(mx_d_r[8]);
  assign arg1 = 10'(sx_d_r[8] ? pa8 : pb8) + 10'(mx_d_r[8]) + 10'(sx_d_r[8]);
  assign arg2 = 10'(pb8) + 10'(mx_d_r[8]) + 10'd1;

  always_ff @(posedge clk) begin
    if (ce) begin
      args9_r[0] <= red289(arg0);
      args9_r[1] <= red289(arg1);
      args9_r[2] <= red289(arg2);
    end
  end

  // Stages 10-12: corner hashes; stages 13-19: corner contributions
  logic [FOLD_W-1:0]  w10_r [3];
  logic [HASH_W-1:0]  p12 [3];
  corner_in_t         cin [3];
  logic signed [31:0] contrib [3];

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) w10_r[k] <= perm_poly(args9_r[k]);
    end
  end

  assign cin[0] = '{ox: ofs_d_r[12].ox0, oy: ofs_d_r[12].oy0, hash: p12[0]};
  assign cin[1] = '{ox: ofs_d_r[12].ox1, oy: ofs_d_r[12].oy1, hash: p12[1]};
  assign cin[2] = '{ox: ofs_d_r[12].ox2, oy: ofs_d_r[12].oy2, hash: p12[2]};

  for (genvar g = 0; g < 3; g++) begin : g_corner
    sn2d_mod289 u_perm (.clk(clk), .ce(ce), .val(w10_r[g]), .res(p12[g]));
    sn2d_corner u_corner (.clk(clk), .ce(ce), .cin(cin[g]), .contrib(contrib[g]));
  end

  // Stage 20: sum of corners
  logic signed [33:0] sum20_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      sum20_r <= 34'(contrib[0]) + 34'(contrib[1]) + 34'(contrib[2]);
    end
  end

  // Stage 21: scale, round to Q1.15, saturate
  logic signed [41:0] scaled;
  logic signed [41:0] rounded;
  logic signed [15:0] noise_nxt;
  logic signed [15:0] noise_r;

  assign scaled  = 42'(sum20_r) * 42'sd130 + 42'sd16384;
  assign rounded = scaled >>> 15;

  always_comb begin
    if (rounded > 42'sd32767) noise_nxt = 16'sh7FFF;
    else if (rounded < -42'sd32768) noise_nxt = -16'sh8000;
    else noise_nxt = rounded[15:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      noise_r <= noise_nxt;
    end
  end

  assign out_ch.noise_value = noise_r;

`ifndef SYNTHESIS
  // A held result freezes every stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> vld_r == $past(vld_r))
    else $error("pipeline moved while stalled");

  // A taken request enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[1])
    else $error("accepted request not in stage 1");

  // First corner offset stays inside +/-2.0
  a_ofs_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> (x0x4_r[OFS_W-1:31] == 3'b000 || x0x4_r[OFS_W-1:31] == 3'b111))
    else $error("corner offset out of range");

  // Cell index residues are reduced
  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> (mx5 < MOD_P && my5 < MOD_P))
    else $error("cell index residue not below 289");

  // Corner hashes are reduced
  a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[12] |-> (p12[0] < MOD_P && p12[1] < MOD_P && p12[2] < MOD_P))
    else $error("corner hash not below 289");
`endif

endmodule
